// ----- rtl/assert_macros.svh -----
// assertion macros included by the prioritiser top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, checked on the rising edge of clk_i outside reset
`define ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(name, ante, cons)
`define ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- rtl/utip_pkg.sv -----
// types, codes and constants of the interrupt prioritiser
package utip_pkg;

  localparam int NUM_TIMERS     = 5;
  localparam int TICK_DECREMENT = 15;
  localparam int CNT_W          = 15;
  localparam int CHAIN_W        = 8;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_MASK  = 3'd2;
  localparam logic [2:0] OP_ACK   = 3'd3;
  localparam logic [2:0] OP_TX    = 3'd4;
  localparam logic [2:0] OP_SENSE = 3'd5;

  localparam logic [1:0] TX_WRITTEN = 2'd0;
  localparam logic [1:0] TX_DONE    = 2'd1;
  localparam logic [1:0] TX_DUE     = 2'd2;

  localparam logic [7:0] VEC_TIMER1 = 8'hc7;
  localparam logic [7:0] VEC_TIMER2 = 8'hcf;
  localparam logic [7:0] VEC_DISK   = 8'hd7;
  localparam logic [7:0] VEC_TIMER3 = 8'hdf;
  localparam logic [7:0] VEC_RX     = 8'he7;
  localparam logic [7:0] VEC_TX     = 8'hef;
  localparam logic [7:0] VEC_TIMER4 = 8'hf7;
  localparam logic [7:0] VEC_TOP    = 8'hff;
  localparam logic [7:0] VEC_SENSE  = 8'hd7;
  localparam logic [7:0] VEC_NONE   = 8'hff;

  // bus vectors of units 1a and 1b: sense, receive, transmit
  localparam logic [1:0][7:0] BUS_SENSE = {8'h34, 8'h24};
  localparam logic [1:0][7:0] BUS_RX    = {8'h38, 8'h28};
  localparam logic [1:0][7:0] BUS_TX    = {8'h3a, 8'h2a};

  localparam logic [7:0] PADDR_RST7 = 8'h00;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       unit;
    logic [CNT_W-1:0] value;
    logic             disk_done;
    logic             rx_ready_a0;
    logic             rx_ready_a1;
    logic             rx_ready_b1;
    logic             clock_event;
  } item_t;

  typedef struct packed {
    logic [NUM_TIMERS-1:0][CNT_W-1:0] timer_cnt;
    logic [NUM_TIMERS-1:0]            timer_pend;
    logic                             irq_busy;
    logic [7:0]                       irq_vector;
    logic [2:0][7:0]                  unit_vector;
    logic [2:0]                       unit_pending;
    logic [2:0][7:0]                  int_mask;
    logic [1:0]                       tx_state_a0;
    logic [1:0]                       tx_empty_pending;
    logic [1:0]                       sense_flag;
    logic                             clock_flag;
  } state_t;

  function automatic state_t state_reset();
    state_t s;
    s = '0;
    s.unit_vector = {3{VEC_NONE}};
    s.tx_state_a0 = TX_DONE;
    return s;
  endfunction

endpackage

// ----- rtl/utip_step.sv -----
// next-state logic for one item: timer countdown, the priority chain, and the load, mask, ack, tx and sense ops
module utip_step (
  input  utip_pkg::state_t state_i,
  input  utip_pkg::item_t  item_i,
  input  logic             rst7_mode_i,
  output utip_pkg::state_t state_o
);

  utip_pkg::state_t                n;
  logic                            hit;
  logic [utip_pkg::CHAIN_W-1:0]    tp;
  logic [utip_pkg::CHAIN_W-1:0]    take;
  logic [7:0]                      m0;
  logic [1:0]                      rx1;

  always_comb begin
    n    = state_i;
    hit  = 1'b0;
    tp   = '0;
    take = '0;
    m0   = state_i.int_mask[0];
    rx1  = {item_i.rx_ready_b1, item_i.rx_ready_a1};
    unique case (item_i.op)
      utip_pkg::OP_TICK: begin
        if (item_i.clock_event) begin
          n.clock_flag = 1'b1;
        end
        if (n.tx_state_a0 == utip_pkg::TX_WRITTEN) begin
          n.tx_state_a0 = utip_pkg::TX_DUE;
        end
        for (int k = 0; k < utip_pkg::NUM_TIMERS; k++) begin
          if (!n.timer_pend[k] && n.timer_cnt[k] != '0) begin
            if (n.timer_cnt[k] <= utip_pkg::CNT_W'(utip_pkg::TICK_DECREMENT)) begin
              n.timer_cnt[k]  = '0;
              n.timer_pend[k] = 1'b1;
            end else begin
              n.timer_cnt[k] = n.timer_cnt[k] - utip_pkg::CNT_W'(utip_pkg::TICK_DECREMENT);
            end
          end
        end
        tp[utip_pkg::NUM_TIMERS-1:0] = n.timer_pend;
        if (!state_i.irq_busy) begin
          priority if (tp[0] && m0[0]) begin
            take[0] = 1'b1;
            hit = 1'b1;
            n.unit_vector[0] = utip_pkg::VEC_TIMER1;
            n.irq_vector     = utip_pkg::VEC_TIMER1;
          end else if (tp[1] && m0[1]) begin
            take[1] = 1'b1;
            hit = 1'b1;
            n.unit_vector[0] = utip_pkg::VEC_TIMER2;
            n.irq_vector     = utip_pkg::VEC_TIMER2;
          end else if (item_i.disk_done && m0[2]) begin
            hit = 1'b1;
            n.unit_vector[0] = utip_pkg::VEC_DISK;
            n.irq_vector     = utip_pkg::VEC_DISK;
          end else if (tp[2] && m0[3]) begin
            take[2] = 1'b1;
            hit = 1'b1;
            n.unit_vector[0] = utip_pkg::VEC_TIMER3;
            n.irq_vector     = utip_pkg::VEC_TIMER3;
          end else if (item_i.rx_ready_a0 && m0[4]) begin
            hit = 1'b1;
            n.unit_vector[0] = utip_pkg::VEC_RX;
            n.irq_vector     = utip_pkg::VEC_RX;
          end else begin
            if (n.tx_state_a0 == utip_pkg::TX_DUE) begin
              n.tx_state_a0 = utip_pkg::TX_DONE;
              if (m0[5]) begin
                hit = 1'b1;
                n.unit_vector[0] = utip_pkg::VEC_TX;
                n.irq_vector     = utip_pkg::VEC_TX;
              end
            end
            if (!hit) begin
              priority if (tp[3] && m0[6]) begin
                take[3] = 1'b1;
                hit = 1'b1;
                n.unit_vector[0] = utip_pkg::VEC_TIMER4;
                n.irq_vector     = utip_pkg::VEC_TIMER4;
              end else if (!rst7_mode_i && tp[4] && m0[7]) begin
                take[4] = 1'b1;
                hit = 1'b1;
                n.unit_vector[0] = utip_pkg::VEC_TOP;
                n.irq_vector     = utip_pkg::VEC_TOP;
              end else if (n.clock_flag && rst7_mode_i) begin
                n.clock_flag = 1'b0;
                if (m0[7]) begin
                  hit = 1'b1;
                  n.unit_vector[0] = utip_pkg::VEC_TOP;
                  n.irq_vector     = utip_pkg::VEC_TOP;
                end
              end
            end
          end
          if (hit) begin
            n.unit_pending[0] = 1'b1;
          end else begin
            n.unit_vector[0]  = utip_pkg::VEC_NONE;
            n.unit_pending[0] = 1'b0;
            // units 1a and 1b in turn
            for (int s = 0; s < 2; s++) begin
              if (!hit) begin
                if (n.sense_flag[s]) begin
                  n.unit_pending[s+1] = 1'b1;
                  n.unit_vector[s+1]  = utip_pkg::VEC_SENSE;
                  if (state_i.int_mask[s+1][2]) begin
                    n.sense_flag[s] = 1'b0;
                    n.irq_vector    = utip_pkg::BUS_SENSE[s];
                    hit = 1'b1;
                  end
                end
                if (!hit && rx1[s] && state_i.int_mask[s+1][4]) begin
                  n.unit_pending[s+1] = 1'b1;
                  n.unit_vector[s+1]  = utip_pkg::VEC_RX;
                  n.irq_vector        = utip_pkg::BUS_RX[s];
                  hit = 1'b1;
                end
                if (!hit && n.tx_empty_pending[s]) begin
                  n.tx_empty_pending[s] = 1'b0;
                  if (state_i.int_mask[s+1][5]) begin
                    n.unit_pending[s+1] = 1'b1;
                    n.unit_vector[s+1]  = utip_pkg::VEC_TX;
                    n.irq_vector        = utip_pkg::BUS_TX[s];
                    hit = 1'b1;
                  end
                end
                if (!hit) begin
                  n.unit_pending[s+1] = 1'b0;
                  n.unit_vector[s+1]  = utip_pkg::VEC_NONE;
                end
              end
            end
          end
          if (hit) begin
            n.irq_busy = 1'b1;
          end
          for (int k = 0; k < utip_pkg::NUM_TIMERS; k++) begin
            if (take[k]) begin
              n.timer_pend[k] = 1'b0;
              n.timer_cnt[k]  = '0;
            end
          end
        end
      end
      utip_pkg::OP_LOAD: begin
        for (int k = 0; k < utip_pkg::NUM_TIMERS; k++) begin
          if (item_i.unit == 3'(k)) begin
            n.timer_cnt[k]  = item_i.value;
            n.timer_pend[k] = 1'b0;
          end
        end
      end
      utip_pkg::OP_MASK: begin
        for (int u = 0; u < 3; u++) begin
          if (item_i.unit == 3'(u)) begin
            n.int_mask[u] = item_i.value[7:0];
          end
        end
      end
      utip_pkg::OP_ACK: begin
        n.irq_busy = 1'b0;
      end
      utip_pkg::OP_TX: begin
        if (item_i.unit == 3'd0) begin
          n.tx_state_a0 = utip_pkg::TX_WRITTEN;
        end
        for (int s = 0; s < 2; s++) begin
          if (item_i.unit == 3'(s + 1)) begin
            n.tx_empty_pending[s] = 1'b1;
          end
        end
      end
      utip_pkg::OP_SENSE: begin
        for (int s = 0; s < 2; s++) begin
          if (item_i.unit == 3'(s + 1)) begin
            n.sense_flag[s] = 1'b1;
          end
        end
      end
      default: begin
        n = state_i;
      end
    endcase
    state_o = n;
  end

endmodule

// ----- rtl/uart_timer_interrupt_prioritizer.sv -----
// Interrupt prioritiser for three serial units with five countdown timers on unit 0a.
// Every input beat is one operation (tick, timer load, mask write, acknowledge, transmit
// write, port sense) and yields exactly one output beat showing the interrupt state after
// it. An operation is applied in the cycle it is accepted: the state registers and the
// output register are loaded together from one pass of next-state logic, so the block
// takes one beat per cycle, and a result appears on the output the cycle after its input
// beat. The output register lets a new beat in while the previous result is being taken;
// input is held off only while that register is full and not being read.
module uart_timer_interrupt_prioritizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // unit, value, disk_done, rx_ready_a0, rx_ready_a1, rx_ready_b1, clock_event
  input  logic [23:0] s_axis_tdata,
  // operation
  input  logic [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // irq_active, bus_vector, vector_a0, vector_a1, vector_b1, pending_a0, pending_a1,
  // pending_b1
  output logic [39:0] m_axis_tdata
);

  utip_pkg::state_t state_q;
  utip_pkg::state_t state_d;
  utip_pkg::item_t  item;
  logic             rst7_mode_q;
  logic             m_valid_q;
  logic [39:0]      m_data_q;
  logic [39:0]      m_data_d;
  logic             s_fire;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == utip_pkg::PADDR_RST7[2:0]);
  assign prdata = (paddr == utip_pkg::PADDR_RST7[2:0]) ? {31'b0, rst7_mode_q} : '0;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign item.op          = s_axis_tuser;
  assign item.unit        = s_axis_tdata[2:0];
  assign item.value       = s_axis_tdata[17:3];
  assign item.disk_done   = s_axis_tdata[18];
  assign item.rx_ready_a0 = s_axis_tdata[19];
  assign item.rx_ready_a1 = s_axis_tdata[20];
  assign item.rx_ready_b1 = s_axis_tdata[21];
  assign item.clock_event = s_axis_tdata[22];

  utip_step u_step (
    .state_i     (state_q),
    .item_i      (item),
    .rst7_mode_i (rst7_mode_q),
    .state_o     (state_d)
  );

  assign m_data_d = {4'b0, state_d.unit_pending[2], state_d.unit_pending[1],
                     state_d.unit_pending[0], state_d.unit_vector[2], state_d.unit_vector[1],
                     state_d.unit_vector[0], state_d.irq_vector, state_d.irq_busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= utip_pkg::state_reset();
      rst7_mode_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        rst7_mode_q <= pwdata[0];
      end
      if (s_fire) begin
        state_q   <= state_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_beat_gives_result, s_fire, m_axis_tvalid)
  `ASSERT_NEXT(a_ack_clears_busy, s_fire && item.op == utip_pkg::OP_ACK, !state_q.irq_busy)
  `ASSERT_IMP(a_busy_has_vector, state_q.irq_busy, state_q.irq_vector != 8'h00)
  `ASSERT_IMP(a_pend_1a_vector, state_q.unit_pending[1],
              state_q.unit_vector[1] != utip_pkg::VEC_NONE)
  `ASSERT_IMP(a_pend_1b_vector, state_q.unit_pending[2],
              state_q.unit_vector[2] != utip_pkg::VEC_NONE)

endmodule
